// ----- hw/rtl/deq_pkg.sv -----
`timescale 1ns / 1ps

package deq_pkg;

  localparam int OP_W    = 2;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_READ       = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic read_hit;
  } stat_t;

endpackage

// ----- hw/rtl/deq_ifs.sv -----
`timescale 1ns / 1ps

interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::OP_W-1:0]            opcode;
  logic signed [deq_pkg::FIELD_W-1:0]  value;
  logic [deq_pkg::POS_W-1:0]           position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink (input valid, opcode, value, position, output ready);
endinterface

interface deq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::FIELD_W-1:0]  read_data;
  logic [deq_pkg::STAT_W-1:0]          status;
  logic [deq_pkg::COUNT_W-1:0]         count_now;
  logic                                is_empty;
  logic signed [deq_pkg::FIELD_W-1:0]  front_value;
  logic signed [deq_pkg::FIELD_W-1:0]  back_value;

  modport source (output valid, read_data, status, count_now, is_empty, front_value,
                  back_value, input ready);
  modport sink (input valid, read_data, status, count_now, is_empty, front_value,
                back_value, output ready);
endinterface

// ----- hw/rtl/deq_ram.sv -----
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/deq_ctrl.sv -----
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  deq_pkg::stat_t stat,
  output deq_pkg::cmd_t  cmd
);

  deq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = stat.read_hit ? deq_pkg::S_READ : deq_pkg::S_RESP;
        end
      end
      deq_pkg::S_READ: begin
        state_next = deq_pkg::S_RESP;
      end
      deq_pkg::S_RESP: begin
        if (rsp_ready) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      deq_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      deq_pkg::S_READ: begin
        cmd.capture = 1'b1;
      end
      deq_pkg::S_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/deq_datapath.sv -----
`timescale 1ns / 1ps

module deq_datapath #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::cmd_t                       cmd,
  output deq_pkg::stat_t                      stat,
  input  logic [deq_pkg::OP_W-1:0]            opcode,
  input  logic signed [deq_pkg::FIELD_W-1:0]  value,
  input  logic [deq_pkg::POS_W-1:0]           position,
  output logic signed [deq_pkg::FIELD_W-1:0]  read_data,
  output logic [deq_pkg::STAT_W-1:0]          status,
  output logic [deq_pkg::COUNT_W-1:0]         count_now,
  output logic                                is_empty,
  output logic signed [deq_pkg::FIELD_W-1:0]  front_value,
  output logic signed [deq_pkg::FIELD_W-1:0]  back_value
);

  localparam int FIELD_W = deq_pkg::FIELD_W;
  localparam int COUNT_W = deq_pkg::COUNT_W;
  localparam int POS_W   = deq_pkg::POS_W;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0]                front_ptr;
  logic [CNT_W-1:0]                count;
  logic signed [FIELD_W-1:0]       front_reg;
  logic signed [FIELD_W-1:0]       back_reg;
  logic signed [FIELD_W-1:0]       data_reg;
  deq_pkg::status_t                status_reg;

  logic                            is_push;
  logic                            is_front;
  logic                            full;
  logic                            read_ok;
  logic [SUM_W-1:0]                rd_sum;
  logic [SUM_W-1:0]                bk_sum;
  logic [SUM_W-1:0]                rd_slot;
  logic [SUM_W-1:0]                bk_slot;
  logic [PTR_W-1:0]                front_dec;
  logic                            we;
  logic                            re;
  logic [PTR_W-1:0]                waddr;
  logic signed [DATA_WIDTH-1:0]    wdata;
  logic signed [DATA_WIDTH-1:0]    rdata;
  logic signed [FIELD_W-1:0]       push_ext;

  always_comb begin
    is_front  = (opcode == deq_pkg::OP_PUSH_FRONT);
    is_push   = is_front || (opcode == deq_pkg::OP_PUSH_BACK);
    full      = (count >= FULL_COUNT);
    read_ok   = (opcode == deq_pkg::OP_READ) && (SUM_W'(position) < SUM_W'(count));
    rd_sum    = SUM_W'(front_ptr) + SUM_W'(position);
    bk_sum    = SUM_W'(front_ptr) + SUM_W'(count);
    rd_slot   = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
    bk_slot   = (bk_sum >= DEPTH_S) ? bk_sum - DEPTH_S : bk_sum;
    front_dec = (front_ptr == '0) ? LAST_SLOT : front_ptr - PTR_W'(1);
    we        = cmd.accept && is_push && !full;
    re        = cmd.accept && read_ok;
    waddr     = is_front ? front_dec : bk_slot[PTR_W-1:0];
    wdata     = DATA_WIDTH'(value);
    push_ext  = FIELD_W'(wdata);
  end

  assign stat.read_hit = read_ok;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_slot[PTR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      count     <= '0;
    end else if (we) begin
      count <= count + CNT_W'(1);
      if (is_front) begin
        front_ptr <= front_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      if (is_front || count == '0) begin
        front_reg <= push_ext;
      end
      if (!is_front || count == '0) begin
        back_reg <= push_ext;
      end
    end
    if (cmd.accept) begin
      data_reg <= '0;
      if (is_push && full) begin
        status_reg <= deq_pkg::ST_FULL;
      end else if (opcode == deq_pkg::OP_READ && !read_ok) begin
        status_reg <= deq_pkg::ST_RANGE;
      end else begin
        status_reg <= deq_pkg::ST_OK;
      end
    end else if (cmd.capture) begin
      data_reg <= FIELD_W'(rdata);
    end
  end

  assign read_data   = data_reg;
  assign status      = status_reg;
  assign count_now   = COUNT_W'(count);
  assign is_empty    = (count == '0);
  assign front_value = is_empty ? '0 : front_reg;
  assign back_value  = is_empty ? '0 : back_reg;

endmodule

// ----- hw/rtl/double_ended_queue_store_top.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed entries in a ring memory with a
// front pointer. One item at a time: a push, an out-of-range read or an
// unused opcode shows its result in the cycle after the request transfer; a
// good read passes through the read state first, as the ring memory has a
// registered read port. A new request is taken in the cycle after the result
// transfer, so a new item is not taken before the last result has gone out.
// Front and back entries are held in registers, so only positional reads
// read from the memory. A push while full is dropped with the full status.
module double_ended_queue_store_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (req.opcode),
    .value       (req.value),
    .position    (req.position),
    .read_data   (rsp.read_data),
    .status      (rsp.status),
    .count_now   (rsp.count_now),
    .is_empty    (rsp.is_empty),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(rsp.valid && req.ready))
    else $error("request taken while a result is pending");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == deq_pkg::ST_FULL |-> rsp.count_now == 7'(DEPTH))
    else $error("push dropped below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != deq_pkg::ST_OK |-> rsp.read_data == '0)
    else $error("read data not zero on failed item");

  a_push_no_read: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.opcode != deq_pkg::OP_READ |=> rsp.valid)
    else $error("non-read item did not respond in one cycle");

endmodule
